// File: rtl/core/pl0ts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl0ts_pkg
// Shared widths, token kinds, scanner modes and token types for the scanner.
// ----------------------------------------------------------------------------
package pl0ts_pkg;

	localparam int LINE_BITS   = 16;
	localparam int COLUMN_BITS = 12;
	localparam int NUMBER_BITS = 32;
	localparam int LENGTH_BITS = 8;
	localparam int KIND_BITS   = 5;
	localparam int ERROR_BITS  = 2;
	localparam int KW_BYTES    = 7;
	localparam int KW_COUNT    = 9;

	// token kinds
	localparam logic [KIND_BITS-1:0] K_IDENT    = 5'd0;
	localparam logic [KIND_BITS-1:0] K_NUMBER   = 5'd1;
	localparam logic [KIND_BITS-1:0] K_KW_FIRST = 5'd2;
	localparam logic [KIND_BITS-1:0] K_PLUS     = 5'd11;
	localparam logic [KIND_BITS-1:0] K_MINUS    = 5'd12;
	localparam logic [KIND_BITS-1:0] K_TIMES    = 5'd13;
	localparam logic [KIND_BITS-1:0] K_SLASH    = 5'd14;
	localparam logic [KIND_BITS-1:0] K_EQ       = 5'd15;
	localparam logic [KIND_BITS-1:0] K_NE       = 5'd16;
	localparam logic [KIND_BITS-1:0] K_LE       = 5'd17;
	localparam logic [KIND_BITS-1:0] K_LT       = 5'd18;
	localparam logic [KIND_BITS-1:0] K_GE       = 5'd19;
	localparam logic [KIND_BITS-1:0] K_GT       = 5'd20;
	localparam logic [KIND_BITS-1:0] K_ASSIGN   = 5'd21;
	localparam logic [KIND_BITS-1:0] K_LPAREN   = 5'd22;
	localparam logic [KIND_BITS-1:0] K_RPAREN   = 5'd23;
	localparam logic [KIND_BITS-1:0] K_SEMI     = 5'd24;
	localparam logic [KIND_BITS-1:0] K_COMMA    = 5'd25;
	localparam logic [KIND_BITS-1:0] K_EOF      = 5'd26;
	localparam logic [KIND_BITS-1:0] K_ERROR    = 5'd27;

	// error codes
	localparam logic [ERROR_BITS-1:0] ERR_NONE    = 2'd0;
	localparam logic [ERROR_BITS-1:0] ERR_COLON   = 2'd1;
	localparam logic [ERROR_BITS-1:0] ERR_ILLEGAL = 2'd2;

	// scanner modes
	localparam logic [2:0] M_START   = 3'd0;
	localparam logic [2:0] M_IDENT   = 3'd1;
	localparam logic [2:0] M_NUMBER  = 3'd2;
	localparam logic [2:0] M_LESS    = 3'd3;
	localparam logic [2:0] M_GREATER = 3'd4;
	localparam logic [2:0] M_COLON   = 3'd5;

	// characters
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_Z   = 8'h5A;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_Z   = 8'h7A;
	localparam logic [7:0] CH_CASE   = 8'h20;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	// keywords, upper case, first byte in the low byte
	localparam logic [8*KW_BYTES-1:0] KW_TEXT [KW_COUNT] = '{
		56'h4D_4152_474F_5250,  // PROGRAM
		56'h00_0000_0052_4156,  // VAR
		56'h00_0054_534E_4F43,  // CONST
		56'h00_004E_4947_4542,  // BEGIN
		56'h00_0000_0044_4E45,  // END
		56'h00_0045_4C49_4857,  // WHILE
		56'h00_0000_0000_4F44,  // DO
		56'h00_0000_0000_4649,  // IF
		56'h00_0000_4E45_4854   // THEN
	};
	localparam logic [LENGTH_BITS-1:0] KW_LEN [KW_COUNT] = '{
		8'd7, 8'd3, 8'd5, 8'd5, 8'd3, 8'd5, 8'd2, 8'd2, 8'd4
	};

	typedef struct packed {
		logic [KIND_BITS-1:0]   kind;
		logic [ERROR_BITS-1:0]  error_code;
		logic [LINE_BITS-1:0]   start_line;
		logic [COLUMN_BITS-1:0] start_column;
		logic [LENGTH_BITS-1:0] length;
		logic [NUMBER_BITS-1:0] number_value;
		logic                   run_end;
	} token_t;

	// tokens caused by one byte, packed from index 0
	typedef struct packed {
		logic [1:0]       count;
		token_t [2:0]     tok;
	} scan_out_t;

	function automatic logic [KIND_BITS-1:0] kw_kind(
		input logic [8*KW_BYTES-1:0] text,
		input logic [LENGTH_BITS-1:0] len
	);
		logic [KIND_BITS-1:0] k;
		k = K_IDENT;
		for (int i = 0; i < KW_COUNT; i++) begin
			if (len == KW_LEN[i] && text == KW_TEXT[i])
				k = K_KW_FIRST + KIND_BITS'(i);
		end
		return k;
	endfunction

endpackage

// File: rtl/core/pl0ts_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl0ts_scan
// Scanner state and next-token logic: one byte in, up to three tokens out.
// ----------------------------------------------------------------------------
module pl0ts_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic [7:0]            ch,
	input  logic                  last,
	output pl0ts_pkg::scan_out_t  res
);

	logic [2:0]                                 mode_q, mode_d;
	logic [8*pl0ts_pkg::KW_BYTES-1:0]           kbuf_q, kbuf_d;
	logic [pl0ts_pkg::LENGTH_BITS-1:0]          len_q, len_d;
	logic [pl0ts_pkg::NUMBER_BITS-1:0]          acc_q, acc_d;
	logic [pl0ts_pkg::LINE_BITS-1:0]            line_q, line_d;
	logic [pl0ts_pkg::COLUMN_BITS-1:0]          col_q, col_d;
	logic [pl0ts_pkg::LINE_BITS-1:0]            sline_q, sline_d;
	logic [pl0ts_pkg::COLUMN_BITS-1:0]          scol_q, scol_d;

	logic [pl0ts_pkg::NUMBER_BITS+3:0]          prod;
	logic [7:0]                                 up;
	logic [7:0]                                 digit;
	logic [pl0ts_pkg::KIND_BITS-1:0]            pair_kind;
	logic [pl0ts_pkg::KIND_BITS-1:0]            sym;
	logic                                       restart;
	logic [2:0]                                 cnt;
	pl0ts_pkg::token_t [2:0]                    toks;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= pl0ts_pkg::CH_UC_A && c <= pl0ts_pkg::CH_UC_Z) ||
			(c >= pl0ts_pkg::CH_LC_A && c <= pl0ts_pkg::CH_LC_Z);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= pl0ts_pkg::CH_ZERO && c <= pl0ts_pkg::CH_NINE;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == pl0ts_pkg::CH_SPACE || (c >= pl0ts_pkg::CH_TAB && c <= pl0ts_pkg::CH_CR);
	endfunction

	function automatic logic [pl0ts_pkg::KIND_BITS-1:0] sym_kind(input logic [7:0] c);
		logic [pl0ts_pkg::KIND_BITS-1:0] k;
		unique case (c)
			pl0ts_pkg::CH_PLUS:   k = pl0ts_pkg::K_PLUS;
			pl0ts_pkg::CH_MINUS:  k = pl0ts_pkg::K_MINUS;
			pl0ts_pkg::CH_STAR:   k = pl0ts_pkg::K_TIMES;
			pl0ts_pkg::CH_SLASH:  k = pl0ts_pkg::K_SLASH;
			pl0ts_pkg::CH_EQ:     k = pl0ts_pkg::K_EQ;
			pl0ts_pkg::CH_LPAREN: k = pl0ts_pkg::K_LPAREN;
			pl0ts_pkg::CH_RPAREN: k = pl0ts_pkg::K_RPAREN;
			pl0ts_pkg::CH_SEMI:   k = pl0ts_pkg::K_SEMI;
			pl0ts_pkg::CH_COMMA:  k = pl0ts_pkg::K_COMMA;
			default:              k = pl0ts_pkg::K_IDENT;
		endcase
		return k;
	endfunction

	function automatic pl0ts_pkg::token_t make_tok(
		input logic [pl0ts_pkg::KIND_BITS-1:0]   kind,
		input logic [pl0ts_pkg::ERROR_BITS-1:0]  err,
		input logic [pl0ts_pkg::LINE_BITS-1:0]   ln,
		input logic [pl0ts_pkg::COLUMN_BITS-1:0] cl,
		input logic [pl0ts_pkg::LENGTH_BITS-1:0] len,
		input logic [pl0ts_pkg::NUMBER_BITS-1:0] val
	);
		pl0ts_pkg::token_t t;
		t.kind         = kind;
		t.error_code   = err;
		t.start_line   = ln;
		t.start_column = cl;
		t.length       = len;
		t.number_value = val;
		t.run_end      = 1'b0;
		return t;
	endfunction

	// token held by a pending mode
	function automatic pl0ts_pkg::token_t pend_tok(
		input logic [2:0]                          mode,
		input logic [8*pl0ts_pkg::KW_BYTES-1:0]    text,
		input logic [pl0ts_pkg::LENGTH_BITS-1:0]   len,
		input logic [pl0ts_pkg::NUMBER_BITS-1:0]   acc,
		input logic [pl0ts_pkg::LINE_BITS-1:0]     ln,
		input logic [pl0ts_pkg::COLUMN_BITS-1:0]   cl
	);
		pl0ts_pkg::token_t t;
		unique case (mode)
			pl0ts_pkg::M_IDENT:
				t = make_tok(pl0ts_pkg::kw_kind(text, len), pl0ts_pkg::ERR_NONE, ln, cl,
					len, '0);
			pl0ts_pkg::M_NUMBER:
				t = make_tok(pl0ts_pkg::K_NUMBER, pl0ts_pkg::ERR_NONE, ln, cl, len, acc);
			pl0ts_pkg::M_LESS:
				t = make_tok(pl0ts_pkg::K_LT, pl0ts_pkg::ERR_NONE, ln, cl, 8'd1, '0);
			pl0ts_pkg::M_GREATER:
				t = make_tok(pl0ts_pkg::K_GT, pl0ts_pkg::ERR_NONE, ln, cl, 8'd1, '0);
			pl0ts_pkg::M_COLON:
				t = make_tok(pl0ts_pkg::K_ERROR, pl0ts_pkg::ERR_COLON, ln, cl, 8'd1, '0);
			default:
				t = '0;
		endcase
		return t;
	endfunction

	function automatic logic is_pending(input logic [2:0] mode);
		return mode == pl0ts_pkg::M_IDENT || mode == pl0ts_pkg::M_NUMBER ||
			mode == pl0ts_pkg::M_LESS || mode == pl0ts_pkg::M_GREATER ||
			mode == pl0ts_pkg::M_COLON;
	endfunction

	always_comb begin
		mode_d  = mode_q;
		kbuf_d  = kbuf_q;
		len_d   = len_q;
		acc_d   = acc_q;
		sline_d = sline_q;
		scol_d  = scol_q;
		toks    = '0;
		cnt     = 3'd0;
		restart = 1'b0;

		up    = (ch >= pl0ts_pkg::CH_LC_A && ch <= pl0ts_pkg::CH_LC_Z) ? ch - pl0ts_pkg::CH_CASE : ch;
		digit = ch - pl0ts_pkg::CH_ZERO;
		sym   = sym_kind(ch);
		prod  = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) +
			(pl0ts_pkg::NUMBER_BITS + 4)'(digit[3:0]);

		// advance position
		if (ch == pl0ts_pkg::CH_LF) begin
			line_d = (line_q != '1) ? line_q + pl0ts_pkg::LINE_BITS'(1) : line_q;
			col_d  = pl0ts_pkg::COLUMN_BITS'(1);
		end else begin
			line_d = line_q;
			col_d  = (col_q != '1) ? col_q + pl0ts_pkg::COLUMN_BITS'(1) : col_q;
		end

		pair_kind = pl0ts_pkg::K_IDENT;
		if (mode_q == pl0ts_pkg::M_LESS && ch == pl0ts_pkg::CH_GT)
			pair_kind = pl0ts_pkg::K_NE;
		else if (mode_q == pl0ts_pkg::M_LESS && ch == pl0ts_pkg::CH_EQ)
			pair_kind = pl0ts_pkg::K_LE;
		else if (mode_q == pl0ts_pkg::M_GREATER && ch == pl0ts_pkg::CH_EQ)
			pair_kind = pl0ts_pkg::K_GE;
		else if (mode_q == pl0ts_pkg::M_COLON && ch == pl0ts_pkg::CH_EQ)
			pair_kind = pl0ts_pkg::K_ASSIGN;

		unique case (mode_q) inside
			pl0ts_pkg::M_IDENT: begin
				if (is_letter(ch) || is_digit(ch)) begin
					if (len_q < pl0ts_pkg::LENGTH_BITS'(pl0ts_pkg::KW_BYTES))
						kbuf_d[{len_q[2:0], 3'b000} +: 8] = up;
					if (len_q != '1)
						len_d = len_q + 8'd1;
				end else begin
					restart = 1'b1;
				end
			end
			pl0ts_pkg::M_NUMBER: begin
				if (is_digit(ch)) begin
					if (prod[pl0ts_pkg::NUMBER_BITS+3 -: 4] != 4'd0)
						acc_d = '1;
					else
						acc_d = prod[pl0ts_pkg::NUMBER_BITS-1:0];
					if (len_q != '1)
						len_d = len_q + 8'd1;
				end else begin
					restart = 1'b1;
				end
			end
			pl0ts_pkg::M_LESS, pl0ts_pkg::M_GREATER, pl0ts_pkg::M_COLON: begin
				if (pair_kind != pl0ts_pkg::K_IDENT) begin
					toks[cnt[1:0]] = make_tok(pair_kind, pl0ts_pkg::ERR_NONE, sline_q, scol_q,
						8'd2, '0);
					cnt    = cnt + 3'd1;
					mode_d = pl0ts_pkg::M_START;
				end else begin
					restart = 1'b1;
				end
			end
			default: begin
				restart = 1'b1;
			end
		endcase

		if (restart) begin
			// close the pending token, then start a new one at this byte unless it is white space
			if (is_pending(mode_q)) begin
				toks[cnt[1:0]] = pend_tok(mode_q, kbuf_q, len_q, acc_q, sline_q, scol_q);
				cnt = cnt + 3'd1;
			end
			mode_d  = pl0ts_pkg::M_START;
			sline_d = line_q;
			scol_d  = col_q;
			if (is_space(ch)) begin
				mode_d = pl0ts_pkg::M_START;
			end else if (is_letter(ch)) begin
				kbuf_d = {{(8*pl0ts_pkg::KW_BYTES-8){1'b0}}, up};
				len_d  = 8'd1;
				mode_d = pl0ts_pkg::M_IDENT;
			end else if (is_digit(ch)) begin
				acc_d  = pl0ts_pkg::NUMBER_BITS'(digit[3:0]);
				len_d  = 8'd1;
				mode_d = pl0ts_pkg::M_NUMBER;
			end else if (ch == pl0ts_pkg::CH_LT) begin
				mode_d = pl0ts_pkg::M_LESS;
			end else if (ch == pl0ts_pkg::CH_GT) begin
				mode_d = pl0ts_pkg::M_GREATER;
			end else if (ch == pl0ts_pkg::CH_COLON) begin
				mode_d = pl0ts_pkg::M_COLON;
			end else if (sym != pl0ts_pkg::K_IDENT) begin
				toks[cnt[1:0]] = make_tok(sym, pl0ts_pkg::ERR_NONE, line_q, col_q, 8'd1, '0);
				cnt = cnt + 3'd1;
			end else begin
				toks[cnt[1:0]] = make_tok(pl0ts_pkg::K_ERROR, pl0ts_pkg::ERR_ILLEGAL, line_q,
					col_q, 8'd1, '0);
				cnt = cnt + 3'd1;
			end
		end

		if (last) begin
			// flush, end of file, then back to reset values
			if (is_pending(mode_d)) begin
				toks[cnt[1:0]] = pend_tok(mode_d, kbuf_d, len_d, acc_d, sline_d, scol_d);
				cnt = cnt + 3'd1;
			end
			toks[cnt[1:0]] = make_tok(pl0ts_pkg::K_EOF, pl0ts_pkg::ERR_NONE, line_d, col_d,
				8'd0, '0);
			cnt     = cnt + 3'd1;
			mode_d  = pl0ts_pkg::M_START;
			kbuf_d  = '0;
			len_d   = '0;
			acc_d   = '0;
			line_d  = pl0ts_pkg::LINE_BITS'(1);
			col_d   = pl0ts_pkg::COLUMN_BITS'(1);
			sline_d = pl0ts_pkg::LINE_BITS'(1);
			scol_d  = pl0ts_pkg::COLUMN_BITS'(1);
		end

		if (cnt != 3'd0)
			toks[cnt[1:0] - 2'd1].run_end = 1'b1;

		res.count = cnt[1:0];
		res.tok   = toks;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= pl0ts_pkg::M_START;
			kbuf_q  <= '0;
			len_q   <= '0;
			acc_q   <= '0;
			line_q  <= pl0ts_pkg::LINE_BITS'(1);
			col_q   <= pl0ts_pkg::COLUMN_BITS'(1);
			sline_q <= pl0ts_pkg::LINE_BITS'(1);
			scol_q  <= pl0ts_pkg::COLUMN_BITS'(1);
		end else if (en) begin
			mode_q  <= mode_d;
			kbuf_q  <= kbuf_d;
			len_q   <= len_d;
			acc_q   <= acc_d;
			line_q  <= line_d;
			col_q   <= col_d;
			sline_q <= sline_d;
			scol_q  <= scol_d;
		end
	end

endmodule

// File: rtl/core/pl0_token_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pl0_token_scanner
// Streaming PL/0 lexer: source bytes in, tokens with position, length and
// number value out.
//
//   channel  valid      ready      payload
//   source   src_valid  src_ready  ch, last
//   token    tok_valid  tok_ready  kind, error_code, start_line, start_column,
//                                  length, number_value, run_end
//
// A byte is held in the input register and scanned when the token queue has
// room for three tokens; its tokens then enter the queue behind any waiting.
// One byte per cycle while each byte yields at most one token and the token
// side takes one token per cycle; a byte that yields more holds up the next.
// Reset empties the queue and returns to line 1, column 1. Stalls on the
// token side back up through the queue into the source handshake.
// ----------------------------------------------------------------------------
module pl0_token_scanner (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  src_valid,
	output logic                                  src_ready,
	input  logic [7:0]                            ch,
	input  logic                                  last,
	output logic                                  tok_valid,
	input  logic                                  tok_ready,
	output logic [pl0ts_pkg::KIND_BITS-1:0]       kind,
	output logic [pl0ts_pkg::ERROR_BITS-1:0]      error_code,
	output logic [pl0ts_pkg::LINE_BITS-1:0]       start_line,
	output logic [pl0ts_pkg::COLUMN_BITS-1:0]     start_column,
	output logic [pl0ts_pkg::LENGTH_BITS-1:0]     length,
	output logic [pl0ts_pkg::NUMBER_BITS-1:0]     number_value,
	output logic                                  run_end
);

	logic                  valid_s1;
	logic [7:0]            ch_s1;
	logic                  last_s1;
	logic                  adv;
	logic                  pop;
	logic [1:0]            head_q;
	logic [2:0]            count_q;
	pl0ts_pkg::token_t     fifo_q [4];
	pl0ts_pkg::token_t     head_tok;
	pl0ts_pkg::scan_out_t  scan;
	logic [1:0]            push_n;

	// scan only with room for a full burst
	assign adv       = valid_s1 && (count_q <= 3'd1);
	assign src_ready = !valid_s1 || adv;
	assign pop       = tok_valid && tok_ready;
	assign push_n    = adv ? scan.count : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (src_ready)
			valid_s1 <= src_valid;
	end

	always_ff @(posedge clk) begin
		if (src_valid && src_ready) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	pl0ts_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.ch     (ch_s1),
		.last   (last_s1),
		.res    (scan)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= 2'd0;
			count_q <= 3'd0;
		end else begin
			if (pop)
				head_q <= head_q + 2'd1;
			count_q <= count_q + {1'b0, push_n} - {2'b00, pop};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < push_n)
				fifo_q[head_q + count_q[1:0] + 2'(i)] <= scan.tok[i];
		end
	end

	assign head_tok     = fifo_q[head_q];
	assign tok_valid    = count_q != 3'd0;
	assign kind         = head_tok.kind;
	assign error_code   = head_tok.error_code;
	assign start_line   = head_tok.start_line;
	assign start_column = head_tok.start_column;
	assign length       = head_tok.length;
	assign number_value = head_tok.number_value;
	assign run_end      = head_tok.run_end;

endmodule
